### hw/rtl/lsq_gradient_accumulator_macros.svh
// ---------------------------------------------------------------------------
// lsq_gradient_accumulator_macros.svh
// Assertion macros shared by the accumulator RTL.
// ---------------------------------------------------------------------------
`ifndef LSQ_GRADIENT_ACCUMULATOR_MACROS_SVH
`define LSQ_GRADIENT_ACCUMULATOR_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define LSQGA_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define LSQGA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/lsqga_pkg.sv
// ---------------------------------------------------------------------------
// lsqga_pkg
// Types, constants and saturating arithmetic for the LSQ gradient accumulator.
// ---------------------------------------------------------------------------
package lsqga_pkg;

    localparam int MAX_FEATURES = 64;
    localparam int IDX_W        = $clog2(MAX_FEATURES);
    localparam int LEN_W        = IDX_W + 1;
    localparam int DATA_W       = 32;
    localparam int ACC_W        = 64;
    localparam int PARAM_W      = 3 * DATA_W;

    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    localparam logic [1:0] MODE_GRAD = 2'd0;
    localparam logic [1:0] MODE_BOTH = 2'd1;

    localparam logic RESP_ROW  = 1'b0;
    localparam logic RESP_GRAD = 1'b1;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_ELEM  = 2'd1,
        REQ_READ  = 2'd2,
        REQ_CLEAR = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        REG_MODE       = 3'd0,
        REG_ACTIVE_SET = 3'd1,
        REG_LENGTH     = 3'd2,
        REG_PROX_ICPT  = 3'd3,
        REG_TRIAL_ICPT = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        SH_DOT     = 2'd0,
        SH_GRAD    = 2'd1,
        SH_HALF_SQ = 2'd2
    } shift_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ_WAIT,
        ST_EL_RD,
        ST_EL_MULP,
        ST_EL_MULT,
        ST_ROW_END,
        ST_W_ISSUE,
        ST_W_RD,
        ST_W_MUL,
        ST_FN_MUL,
        ST_QFN_MUL,
        ST_FINISH
    } state_t;

    typedef struct packed {
        req_t                     kind;
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] pc;
        logic signed [DATA_W-1:0] tc;
        logic signed [DATA_W-1:0] mean;
        logic signed [DATA_W-1:0] y;
        logic                     last;
        logic                     in_len;
    } item_t;

    typedef struct packed {
        logic [1:0]               mode;
        logic                     use_active;
        logic [LEN_W-1:0]         used_len;
        logic signed [DATA_W-1:0] prox_icpt;
        logic signed [DATA_W-1:0] trial_icpt;
    } cfg_t;

    typedef struct packed {
        logic                    valid;
        logic                    kind;
        logic signed [ACC_W-1:0] grad;
        logic [ACC_W-2:0]        fn;
        logic [ACC_W-2:0]        qfn;
        logic                    ovf;
    } resp_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] value;
        logic                    ovf;
    } sat_t;

    function automatic sat_t sat_add(input logic signed [ACC_W-1:0] a,
                                     input logic signed [ACC_W-1:0] b);
        logic signed [ACC_W:0] s;
        sat_t r;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        r.ovf = s[ACC_W] ^ s[ACC_W-1];
        r.value = r.ovf ? (s[ACC_W] ? ACC_MIN : ACC_MAX) : s[ACC_W-1:0];
        return r;
    endfunction

    function automatic sat_t sat_sub(input logic signed [ACC_W-1:0] a,
                                     input logic signed [ACC_W-1:0] b);
        logic signed [ACC_W:0] s;
        sat_t r;
        s = {a[ACC_W-1], a} - {b[ACC_W-1], b};
        r.ovf = s[ACC_W] ^ s[ACC_W-1];
        r.value = r.ovf ? (s[ACC_W] ? ACC_MIN : ACC_MAX) : s[ACC_W-1:0];
        return r;
    endfunction

endpackage

### hw/rtl/lsqga_ram.sv
// ---------------------------------------------------------------------------
// lsqga_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module lsqga_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hw/rtl/lsqga_mul.sv
// ---------------------------------------------------------------------------
// lsqga_mul
// Multi-cycle signed 64x64 multiply, shift toward zero and saturate.
// ---------------------------------------------------------------------------
module lsqga_mul
    import lsqga_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [ACC_W-1:0] a,
    input  logic signed [ACC_W-1:0] b,
    input  shift_t                  sh,
    output logic                    done,
    output logic signed [ACC_W-1:0] result,
    output logic                    ovf
);

    logic                   active_reg;
    logic [2:0]             cnt_reg;
    logic [ACC_W-1:0]       ua_reg;
    logic [ACC_W-1:0]       ub_reg;
    logic                   neg_reg;
    shift_t                 sh_reg;
    logic [ACC_W-1:0]       prod_reg;
    logic [1:0]             pos_reg;
    logic [2*ACC_W-1:0]     acc_reg;
    logic                   done_reg;
    logic signed [ACC_W-1:0] result_reg;
    logic                   ovf_reg;

    logic [DATA_W-1:0]      a_part;
    logic [DATA_W-1:0]      b_part;
    logic [2*ACC_W-1:0]     prod_sh;
    logic [2*ACC_W-1:0]     shifted;
    logic [ACC_W-1:0]       limit;
    logic                   sat;
    logic [ACC_W-1:0]       mag;

    always_comb
    begin
        a_part = cnt_reg[1] ? ua_reg[ACC_W-1:DATA_W] : ua_reg[DATA_W-1:0];
        b_part = cnt_reg[0] ? ub_reg[ACC_W-1:DATA_W] : ub_reg[DATA_W-1:0];
        case (pos_reg)
            2'd0:    prod_sh = {{ACC_W{1'b0}}, prod_reg};
            2'd1:    prod_sh = {{DATA_W{1'b0}}, prod_reg, {DATA_W{1'b0}}};
            default: prod_sh = {prod_reg, {ACC_W{1'b0}}};
        endcase
        case (sh_reg)
            SH_DOT:     shifted = acc_reg >> 8;
            SH_GRAD:    shifted = acc_reg >> 24;
            SH_HALF_SQ: shifted = acc_reg >> 41;
            default:    shifted = acc_reg;
        endcase
        limit = neg_reg ? ACC_MIN : ACC_MAX;
        sat   = (|shifted[2*ACC_W-1:ACC_W]) || (shifted[ACC_W-1:0] > limit);
        mag   = sat ? limit : shifted[ACC_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= '0;
            end
            else if (active_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd5)
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ua_reg  <= a[ACC_W-1] ? (~a + 64'd1) : a;
            ub_reg  <= b[ACC_W-1] ? (~b + 64'd1) : b;
            neg_reg <= a[ACC_W-1] ^ b[ACC_W-1];
            sh_reg  <= sh;
            acc_reg <= '0;
        end
        else if (active_reg)
        begin
            if (cnt_reg < 3'd4)
            begin
                prod_reg <= a_part * b_part;
                pos_reg  <= {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
            end
            if (cnt_reg >= 3'd1 && cnt_reg <= 3'd4)
            begin
                acc_reg <= acc_reg + prod_sh;
            end
            if (cnt_reg == 3'd5)
            begin
                result_reg <= neg_reg ? (~mag + 64'd1) : mag;
                ovf_reg    <= sat;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;
    assign ovf    = ovf_reg;

endmodule

### hw/rtl/lsqga_front.sv
// ---------------------------------------------------------------------------
// lsqga_front
// Command intake: classify each beat and hold it in a two-entry queue.
// ---------------------------------------------------------------------------
module lsqga_front
    import lsqga_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [1:0]               req_type,
    input  logic [IDX_W-1:0]         feature_index,
    input  logic signed [DATA_W-1:0] x_value,
    input  logic signed [DATA_W-1:0] prox_coef_value,
    input  logic signed [DATA_W-1:0] trial_coef_value,
    input  logic signed [DATA_W-1:0] mean_value,
    input  logic signed [DATA_W-1:0] y_value,
    input  logic                     last_element,
    input  logic [LEN_W-1:0]         used_len,
    output logic                     busy,
    output logic                     item_valid,
    output item_t                    item,
    input  logic                     pop
);

    item_t      q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    item_t      in_item;

    always_comb
    begin
        in_item.kind   = req_t'(req_type);
        in_item.idx    = feature_index;
        in_item.x      = x_value;
        in_item.pc     = prox_coef_value;
        in_item.tc     = trial_coef_value;
        in_item.mean   = mean_value;
        in_item.y      = y_value;
        in_item.last   = last_element;
        in_item.in_len = {1'b0, feature_index} < used_len;
    end

    assign busy       = (count_reg == 2'd2);
    assign push       = start && !busy;
    assign item_valid = (count_reg != 2'd0);
    assign item       = q_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

### hw/rtl/lsqga_back.sv
// ---------------------------------------------------------------------------
// lsqga_back
// Execution side: stores, dot products, row-end gradient walk and fn/qfn.
// ---------------------------------------------------------------------------
module lsqga_back
    import lsqga_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  item_valid,
    input  item_t item,
    output logic  pop,
    output resp_t resp
);

    state_t state_reg, state_next;

    item_t                   cur_reg;
    logic signed [ACC_W-1:0] prox_dot_reg;
    logic signed [ACC_W-1:0] trial_dot_reg;
    logic signed [ACC_W-1:0] fn_reg;
    logic signed [ACC_W-1:0] qfn_reg;
    logic                    ovf_reg;
    logic signed [ACC_W-1:0] resid_reg;
    logic signed [ACC_W-1:0] grad_cur_reg;
    logic [LEN_W-1:0]        walk_reg;
    logic [MAX_FEATURES-1:0] pvalid_reg;
    logic [MAX_FEATURES-1:0] gvalid_reg;
    logic                    rd_pv_reg;
    logic                    rd_gv_reg;
    resp_t                   resp_reg;

    // memory ports
    logic                p_we, p_re, r_we, r_re, g_we, g_re;
    logic [IDX_W-1:0]    p_waddr, p_raddr, r_waddr, r_raddr, g_waddr, g_raddr;
    logic [PARAM_W-1:0]  p_wdata, p_rdata, pword;
    logic [DATA_W-1:0]   r_wdata, r_rdata;
    logic [ACC_W-1:0]    g_wdata, g_rdata, gword;

    logic                    mul_start, mul_done, mul_ovf;
    logic signed [ACC_W-1:0] mul_a, mul_b, mul_res;
    shift_t                  mul_sh;

    logic signed [DATA_W-1:0] w_prox, w_trial, w_mean;
    logic signed [DATA_W:0]   diff_p, diff_t, dmx;
    logic signed [ACC_W-1:0]  base_p, base_t;
    sat_t res_p, res_t, add_pd, add_td, add_fn, add_qfn, add_g;

    lsqga_ram #(.WIDTH(PARAM_W), .DEPTH(MAX_FEATURES)) u_param_ram (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .re(p_re), .raddr(p_raddr), .rdata(p_rdata)
    );

    lsqga_ram #(.WIDTH(DATA_W), .DEPTH(MAX_FEATURES)) u_row_ram (
        .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
        .re(r_re), .raddr(r_raddr), .rdata(r_rdata)
    );

    lsqga_ram #(.WIDTH(ACC_W), .DEPTH(MAX_FEATURES)) u_grad_ram (
        .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
        .re(g_re), .raddr(g_raddr), .rdata(g_rdata)
    );

    lsqga_mul u_mul (
        .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
        .sh(mul_sh), .done(mul_done), .result(mul_res), .ovf(mul_ovf)
    );

    // Entries never loaded since reset (or cleared) read as zero.
    always_comb
    begin
        pword   = rd_pv_reg ? p_rdata : '0;
        gword   = rd_gv_reg ? g_rdata : '0;
        w_prox  = pword[3*DATA_W-1:2*DATA_W];
        w_trial = pword[2*DATA_W-1:DATA_W];
        w_mean  = pword[DATA_W-1:0];
        diff_p  = {cur_reg.y[DATA_W-1], cur_reg.y}
                - {cfg.prox_icpt[DATA_W-1], cfg.prox_icpt};
        diff_t  = {cur_reg.y[DATA_W-1], cur_reg.y}
                - {cfg.trial_icpt[DATA_W-1], cfg.trial_icpt};
        base_p  = {{(ACC_W-DATA_W-17){diff_p[DATA_W]}}, diff_p, 16'b0};
        base_t  = {{(ACC_W-DATA_W-17){diff_t[DATA_W]}}, diff_t, 16'b0};
        dmx     = {w_mean[DATA_W-1], w_mean} - {r_rdata[DATA_W-1], r_rdata};
        res_p   = sat_sub(base_p, prox_dot_reg);
        res_t   = sat_sub(base_t, trial_dot_reg);
        add_pd  = sat_add(prox_dot_reg, mul_res);
        add_td  = sat_add(trial_dot_reg, mul_res);
        add_fn  = sat_add(fn_reg, mul_res);
        add_qfn = sat_add(qfn_reg, mul_res);
        add_g   = sat_add(grad_cur_reg, mul_res);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pop       = 1'b0;
        p_we      = 1'b0;
        p_waddr   = item.idx;
        p_wdata   = {item.pc, item.tc, item.mean};
        p_re      = 1'b0;
        p_raddr   = item.idx;
        r_we      = 1'b0;
        r_waddr   = item.idx;
        r_wdata   = item.x;
        r_re      = 1'b0;
        r_raddr   = walk_reg[IDX_W-1:0];
        g_we      = 1'b0;
        g_waddr   = walk_reg[IDX_W-1:0];
        g_wdata   = add_g.value;
        g_re      = 1'b0;
        g_raddr   = item.idx;
        mul_start = 1'b0;
        mul_a     = {{(ACC_W-DATA_W){w_prox[DATA_W-1]}}, w_prox};
        mul_b     = {{(ACC_W-DATA_W){cur_reg.x[DATA_W-1]}}, cur_reg.x};
        mul_sh    = SH_DOT;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    pop = 1'b1;
                    case (item.kind)
                        REQ_LOAD:
                        begin
                            p_we = 1'b1;
                        end
                        REQ_READ:
                        begin
                            g_re       = 1'b1;
                            state_next = ST_READ_WAIT;
                        end
                        REQ_ELEM:
                        begin
                            if (item.in_len)
                            begin
                                r_we       = 1'b1;
                                p_re       = 1'b1;
                                state_next = ST_EL_RD;
                            end
                            else if (item.last)
                            begin
                                state_next = ST_ROW_END;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_READ_WAIT:
            begin
                state_next = ST_IDLE;
            end
            ST_EL_RD:
            begin
                mul_start  = 1'b1;
                state_next = ST_EL_MULP;
            end
            ST_EL_MULP:
            begin
                mul_a = {{(ACC_W-DATA_W){w_trial[DATA_W-1]}}, w_trial};
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    state_next = ST_EL_MULT;
                end
            end
            ST_EL_MULT:
            begin
                if (mul_done)
                begin
                    state_next = cur_reg.last ? ST_ROW_END : ST_IDLE;
                end
            end
            ST_ROW_END:
            begin
                if (cfg.mode == MODE_GRAD)
                begin
                    state_next = ST_W_ISSUE;
                end
                else
                begin
                    mul_start  = 1'b1;
                    mul_a      = res_t.value;
                    mul_b      = res_t.value;
                    mul_sh     = SH_HALF_SQ;
                    state_next = ST_FN_MUL;
                end
            end
            ST_W_ISSUE:
            begin
                if (walk_reg == cfg.used_len)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    p_re       = 1'b1;
                    p_raddr    = walk_reg[IDX_W-1:0];
                    r_re       = 1'b1;
                    g_re       = 1'b1;
                    g_raddr    = walk_reg[IDX_W-1:0];
                    state_next = ST_W_RD;
                end
            end
            ST_W_RD:
            begin
                if (cfg.use_active && (w_prox == '0))
                begin
                    state_next = ST_W_ISSUE;
                end
                else
                begin
                    mul_start  = 1'b1;
                    mul_a      = {{(ACC_W-DATA_W-1){dmx[DATA_W]}}, dmx};
                    mul_b      = resid_reg;
                    mul_sh     = SH_GRAD;
                    state_next = ST_W_MUL;
                end
            end
            ST_W_MUL:
            begin
                if (mul_done)
                begin
                    g_we       = 1'b1;
                    state_next = ST_W_ISSUE;
                end
            end
            ST_FN_MUL:
            begin
                if (mul_done)
                begin
                    if (cfg.mode == MODE_BOTH)
                    begin
                        mul_start  = 1'b1;
                        mul_a      = res_p.value;
                        mul_b      = res_p.value;
                        mul_sh     = SH_HALF_SQ;
                        state_next = ST_QFN_MUL;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_QFN_MUL:
            begin
                if (mul_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prox_dot_reg  <= '0;
            trial_dot_reg <= '0;
            fn_reg        <= '0;
            qfn_reg       <= '0;
            ovf_reg       <= 1'b0;
            pvalid_reg    <= '0;
            gvalid_reg    <= '0;
            walk_reg      <= '0;
            resp_reg      <= '0;
        end
        else
        begin
            resp_reg.valid <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (item_valid)
                    begin
                        case (item.kind)
                            REQ_LOAD:
                            begin
                                pvalid_reg[item.idx] <= 1'b1;
                            end
                            REQ_CLEAR:
                            begin
                                gvalid_reg    <= '0;
                                prox_dot_reg  <= '0;
                                trial_dot_reg <= '0;
                                fn_reg        <= '0;
                                qfn_reg       <= '0;
                                ovf_reg       <= 1'b0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_READ_WAIT:
                begin
                    resp_reg.valid <= 1'b1;
                    resp_reg.kind  <= RESP_GRAD;
                    resp_reg.grad  <= gword;
                    resp_reg.fn    <= fn_reg[ACC_W-2:0];
                    resp_reg.qfn   <= qfn_reg[ACC_W-2:0];
                    resp_reg.ovf   <= ovf_reg;
                end
                ST_EL_MULP:
                begin
                    if (mul_done)
                    begin
                        prox_dot_reg <= add_pd.value;
                        ovf_reg      <= ovf_reg | mul_ovf | add_pd.ovf;
                    end
                end
                ST_EL_MULT:
                begin
                    if (mul_done)
                    begin
                        trial_dot_reg <= add_td.value;
                        ovf_reg       <= ovf_reg | mul_ovf | add_td.ovf;
                    end
                end
                ST_ROW_END:
                begin
                    walk_reg <= '0;
                    if (cfg.mode == MODE_GRAD)
                    begin
                        ovf_reg <= ovf_reg | res_p.ovf;
                    end
                    else
                    begin
                        ovf_reg <= ovf_reg | res_t.ovf;
                    end
                end
                ST_W_RD:
                begin
                    if (cfg.use_active && (w_prox == '0))
                    begin
                        walk_reg <= walk_reg + LEN_W'(1);
                    end
                end
                ST_W_MUL:
                begin
                    if (mul_done)
                    begin
                        gvalid_reg[walk_reg[IDX_W-1:0]] <= 1'b1;
                        ovf_reg  <= ovf_reg | mul_ovf | add_g.ovf;
                        walk_reg <= walk_reg + LEN_W'(1);
                    end
                end
                ST_FN_MUL:
                begin
                    if (mul_done)
                    begin
                        fn_reg  <= add_fn.value;
                        ovf_reg <= ovf_reg | mul_ovf | add_fn.ovf
                                 | ((cfg.mode == MODE_BOTH) & res_p.ovf);
                    end
                end
                ST_QFN_MUL:
                begin
                    if (mul_done)
                    begin
                        qfn_reg <= add_qfn.value;
                        ovf_reg <= ovf_reg | mul_ovf | add_qfn.ovf;
                    end
                end
                ST_FINISH:
                begin
                    prox_dot_reg   <= '0;
                    trial_dot_reg  <= '0;
                    resp_reg.valid <= 1'b1;
                    resp_reg.kind  <= RESP_ROW;
                    resp_reg.grad  <= '0;
                    resp_reg.fn    <= fn_reg[ACC_W-2:0];
                    resp_reg.qfn   <= qfn_reg[ACC_W-2:0];
                    resp_reg.ovf   <= ovf_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload and read-tag registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && item_valid)
        begin
            cur_reg   <= item;
            rd_pv_reg <= pvalid_reg[item.idx];
            rd_gv_reg <= gvalid_reg[item.idx];
        end
        if (state_reg == ST_ROW_END)
        begin
            resid_reg <= res_p.value;
        end
        if (state_reg == ST_W_ISSUE)
        begin
            rd_pv_reg <= pvalid_reg[walk_reg[IDX_W-1:0]];
            rd_gv_reg <= gvalid_reg[walk_reg[IDX_W-1:0]];
        end
        if (state_reg == ST_W_RD)
        begin
            grad_cur_reg <= gword;
        end
    end

    assign resp = resp_reg;

endmodule

### hw/rtl/lsq_gradient_accumulator.sv
// ---------------------------------------------------------------------------
// lsq_gradient_accumulator
// Per-row least-squares gradient and fn/qfn accumulation, Q8.24 in, Q24.40 out.
// ---------------------------------------------------------------------------
//
//  Channel   Handshake                          Payload
//  -------   ---------------------------------  ------------------------------
//  command   start, busy (beat when !busy)      req_type .. last_element
//  result    resp_valid (one-cycle strobe)      resp_kind .. overflow
//  config    APB: psel, penable, pwrite, pready paddr, pwdata, prdata
//
//  Load and clear complete in the idle state of the back end; a gradient read
//  also passes through a read-wait state. A row element goes through dispatch,
//  operand read and two serial passes through the shared multiplier (4 partial
//  products of 32x32 each per pass). Row end in mode 0 walks active_length
//  features, each read, multiplied and written back unless skipped by the active set;
//  modes 1 to 3 take one or two multiplier passes. The 2-beat queue takes
//  commands while the back end works; busy is high when it is full.
//  Reset: async, active low; parameter and gradient stores come back as
//  zero through valid bits, with no clearing pass. Results cannot be stalled.
// ---------------------------------------------------------------------------
`include "lsq_gradient_accumulator_macros.svh"

module lsq_gradient_accumulator
    import lsqga_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // command channel
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               req_type,
    input  logic [IDX_W-1:0]         feature_index,
    input  logic signed [DATA_W-1:0] x_value,
    input  logic signed [DATA_W-1:0] prox_coef_value,
    input  logic signed [DATA_W-1:0] trial_coef_value,
    input  logic signed [DATA_W-1:0] mean_value,
    input  logic signed [DATA_W-1:0] y_value,
    input  logic                     last_element,
    // result channel
    output logic                     resp_valid,
    output logic                     resp_kind,
    output logic signed [ACC_W-1:0]  gradient_value,
    output logic [ACC_W-2:0]         fn_sum,
    output logic [ACC_W-2:0]         qfn_sum,
    output logic                     overflow,
    // configuration port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [4:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    logic [1:0]               mode_reg;
    logic                     use_active_reg;
    logic [LEN_W-1:0]         length_reg;
    logic signed [DATA_W-1:0] prox_icpt_reg;
    logic signed [DATA_W-1:0] trial_icpt_reg;

    logic     cfg_write;
    reg_idx_t reg_sel;
    cfg_t     cfg;
    logic     item_valid;
    item_t    item;
    logic     pop;
    resp_t    resp;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_sel   = reg_idx_t'(paddr[4:2]);

    // Register writes land on the access beat of the APB transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_GRAD;
            use_active_reg <= 1'b0;
            length_reg     <= LEN_W'(MAX_FEATURES);
            prox_icpt_reg  <= '0;
            trial_icpt_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_MODE:       mode_reg       <= pwdata[1:0];
                REG_ACTIVE_SET: use_active_reg <= pwdata[0];
                REG_LENGTH:     length_reg     <= pwdata[LEN_W-1:0];
                REG_PROX_ICPT:  prox_icpt_reg  <= pwdata;
                REG_TRIAL_ICPT: trial_icpt_reg <= pwdata;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_MODE:       prdata = {30'b0, mode_reg};
            REG_ACTIVE_SET: prdata = {31'b0, use_active_reg};
            REG_LENGTH:     prdata = {{(32-LEN_W){1'b0}}, length_reg};
            REG_PROX_ICPT:  prdata = prox_icpt_reg;
            REG_TRIAL_ICPT: prdata = trial_icpt_reg;
            default:        prdata = '0;
        endcase
    end

    // Clamp the row length to the store depth.
    always_comb
    begin
        cfg.mode       = mode_reg;
        cfg.use_active = use_active_reg;
        cfg.used_len   = (length_reg > LEN_W'(MAX_FEATURES)) ? LEN_W'(MAX_FEATURES)
                                                             : length_reg;
        cfg.prox_icpt  = prox_icpt_reg;
        cfg.trial_icpt = trial_icpt_reg;
    end

    lsqga_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .req_type         (req_type),
        .feature_index    (feature_index),
        .x_value          (x_value),
        .prox_coef_value  (prox_coef_value),
        .trial_coef_value (trial_coef_value),
        .mean_value       (mean_value),
        .y_value          (y_value),
        .last_element     (last_element),
        .used_len         (cfg.used_len),
        .busy             (busy),
        .item_valid       (item_valid),
        .item             (item),
        .pop              (pop)
    );

    lsqga_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .pop        (pop),
        .resp       (resp)
    );

    // Drive the result beat straight from the back end's output register.
    assign resp_valid     = resp.valid;
    assign resp_kind      = resp.kind;
    assign gradient_value = resp.grad;
    assign fn_sum         = resp.fn;
    assign qfn_sum        = resp.qfn;
    assign overflow       = resp.ovf;

    `LSQGA_ASSERT_NEXT(a_resp_single, resp_valid, !resp_valid, "result strobe held twice")
    `LSQGA_ASSERT_IMPLY(a_row_grad_zero, resp_valid && (resp_kind == RESP_ROW), gradient_value == '0, "row result carries gradient data")

endmodule

### tb/lsqga_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsqga_checker
// Watches the command, result and register channels of the accumulator. It
// keeps its own copy of the stores and registers, predicts each result in
// Q24.40 and compares the results in order.
// ----------------------------------------------------------------------------
module lsqga_checker
    import lsqga_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic [1:0]               req_type,
    input  logic [IDX_W-1:0]         feature_index,
    input  logic signed [DATA_W-1:0] x_value,
    input  logic signed [DATA_W-1:0] prox_coef_value,
    input  logic signed [DATA_W-1:0] trial_coef_value,
    input  logic signed [DATA_W-1:0] mean_value,
    input  logic signed [DATA_W-1:0] y_value,
    input  logic                     last_element,
    input  logic                     resp_valid,
    input  logic                     resp_kind,
    input  logic signed [ACC_W-1:0]  gradient_value,
    input  logic [ACC_W-2:0]         fn_sum,
    input  logic [ACC_W-2:0]         qfn_sum,
    input  logic                     overflow,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic                     pready,
    input  logic [4:0]               paddr,
    input  logic [31:0]              pwdata,
    output int                       mismatches,
    output int                       outstanding,
    output int                       rows_seen,
    output int                       reads_seen
);

    typedef struct {
        logic             kind;
        longint           grad;
        logic [ACC_W-2:0] fn;
        logic [ACC_W-2:0] qfn;
        logic             ovf;
    } answer_t;

    answer_t answers[$];

    logic [1:0] mode_r;
    logic       active_r;
    logic [6:0] length_r;
    longint     prox_icpt_r;
    longint     trial_icpt_r;

    longint prox_coef[MAX_FEATURES];
    longint trial_coef[MAX_FEATURES];
    longint mean_tab[MAX_FEATURES];
    longint grad_tab[MAX_FEATURES];
    longint row_x[MAX_FEATURES];
    longint prox_dot;
    longint trial_dot;
    longint fn_total;
    longint qfn_total;
    logic   sat_hit;

    // magnitude product, shifted and truncated toward zero, then saturated
    function automatic longint mul_trunc(longint a, longint b, int sh);
        logic         neg;
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [63:0]  lim;
        logic [127:0] p;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? -a : a;
        ub  = (b < 0) ? -b : b;
        p   = {64'd0, ua} * {64'd0, ub};
        p   = p >> sh;
        lim = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
        if (p[127:64] != 0 || p[63:0] > lim)
        begin
            sat_hit  = 1'b1;
            p[63:0] = lim;
        end
        return neg ? longint'(-p[63:0]) : longint'(p[63:0]);
    endfunction

    function automatic longint clamp65(logic [64:0] s);
        if (s[64] != s[63])
        begin
            sat_hit = 1'b1;
            return s[64] ? longint'(ACC_MIN) : longint'(ACC_MAX);
        end
        return longint'(s[63:0]);
    endfunction

    function automatic longint add_sat(longint a, longint b);
        return clamp65({a[63], a} + {b[63], b});
    endfunction

    function automatic longint sub_sat(longint a, longint b);
        return clamp65({a[63], a} - {b[63], b});
    endfunction

    function automatic longint resid(longint y, longint icpt, longint dot);
        return sub_sat(y * 65536 - icpt * 65536, dot);
    endfunction

    function automatic int span();
        return (length_r > MAX_FEATURES) ? MAX_FEATURES : int'(length_r);
    endfunction

    task automatic close_row(longint y);
        longint r;
        longint rq;
        if (mode_r == MODE_GRAD)
        begin
            r = resid(y, prox_icpt_r, prox_dot);
            for (int i = 0; i < span(); i++)
                if (!(active_r && prox_coef[i] == 0))
                    grad_tab[i] = add_sat(grad_tab[i],
                        mul_trunc(mean_tab[i] - row_x[i], r, 24));
        end
        else
        begin
            // modes two and three fall through here as fn only
            r = resid(y, trial_icpt_r, trial_dot);
            fn_total = add_sat(fn_total, mul_trunc(r, r, 41));
            if (mode_r == MODE_BOTH)
            begin
                rq = resid(y, prox_icpt_r, prox_dot);
                qfn_total = add_sat(qfn_total, mul_trunc(rq, rq, 41));
            end
        end
        prox_dot  = 0;
        trial_dot = 0;
    endtask

    task automatic take_beat();
        answer_t a;
        int      k;
        k = feature_index;
        case (req_t'(req_type))
            REQ_LOAD:
            begin
                prox_coef[k]  = prox_coef_value;
                trial_coef[k] = trial_coef_value;
                mean_tab[k]   = mean_value;
            end
            REQ_CLEAR:
            begin
                foreach (grad_tab[i])
                    grad_tab[i] = 0;
                prox_dot  = 0;
                trial_dot = 0;
                fn_total  = 0;
                qfn_total = 0;
                sat_hit   = 1'b0;
            end
            REQ_ELEM:
            begin
                if (k < span())
                begin
                    row_x[k]  = x_value;
                    prox_dot  = add_sat(prox_dot, mul_trunc(prox_coef[k], x_value, 8));
                    trial_dot = add_sat(trial_dot, mul_trunc(trial_coef[k], x_value, 8));
                end
                if (last_element)
                begin
                    close_row(y_value);
                    a.kind = RESP_ROW;
                    a.grad = 0;
                end
            end
            default:
            begin
                a.kind = RESP_GRAD;
                a.grad = grad_tab[k];
            end
        endcase
        if (req_t'(req_type) == REQ_READ || (req_t'(req_type) == REQ_ELEM && last_element))
        begin
            a.fn  = fn_total[62:0];
            a.qfn = qfn_total[62:0];
            a.ovf = sat_hit;
            answers.push_back(a);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        answer_t a;
        int      errs;
        errs = 0;
        if (!rst_n)
        begin
            answers.delete();
            mode_r       <= MODE_GRAD;
            active_r     <= 1'b0;
            length_r     <= 7'd64;
            prox_icpt_r  <= 0;
            trial_icpt_r <= 0;
            prox_dot     = 0;
            trial_dot    = 0;
            fn_total     = 0;
            qfn_total    = 0;
            sat_hit      = 1'b0;
            foreach (grad_tab[i])
            begin
                prox_coef[i]  = 0;
                trial_coef[i] = 0;
                mean_tab[i]   = 0;
                grad_tab[i]   = 0;
                row_x[i]      = 0;
            end
            mismatches  <= 0;
            outstanding <= 0;
            rows_seen   <= 0;
            reads_seen  <= 0;
        end
        else
        begin
            // compare before predicting: a result never belongs to this edge's beat
            if (resp_valid)
            begin
                if (answers.size() == 0)
                begin
                    $error("result beat with no expectation waiting");
                    errs++;
                end
                else
                begin
                    a = answers.pop_front();
                    if (resp_kind !== a.kind)
                    begin
                        $error("resp_kind expected %0d got %0d", a.kind, resp_kind);
                        errs++;
                    end
                    if (gradient_value !== a.grad)
                    begin
                        $error("gradient_value expected %0d got %0d", a.grad, gradient_value);
                        errs++;
                    end
                    if (fn_sum !== a.fn)
                    begin
                        $error("fn_sum expected %0h got %0h", a.fn, fn_sum);
                        errs++;
                    end
                    if (qfn_sum !== a.qfn)
                    begin
                        $error("qfn_sum expected %0h got %0h", a.qfn, qfn_sum);
                        errs++;
                    end
                    if (overflow !== a.ovf)
                    begin
                        $error("overflow expected %0d got %0d", a.ovf, overflow);
                        errs++;
                    end
                    if (a.kind == RESP_ROW)
                        rows_seen <= rows_seen + 1;
                    else
                        reads_seen <= reads_seen + 1;
                end
            end
            mismatches <= mismatches + errs;
            if (start && !busy)
                take_beat();
            if (psel && penable && pwrite && pready)
                case (reg_idx_t'(paddr[4:2]))
                    REG_MODE:       mode_r       <= pwdata[1:0];
                    REG_ACTIVE_SET: active_r     <= pwdata[0];
                    REG_LENGTH:     length_r     <= pwdata[6:0];
                    REG_PROX_ICPT:  prox_icpt_r  <= longint'(signed'(pwdata));
                    REG_TRIAL_ICPT: trial_icpt_r <= longint'(signed'(pwdata));
                    default: ;
                endcase
            outstanding <= answers.size();
        end
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives commands and register writes into the LSQ gradient accumulator.
// Register settings change between segments of random rows, loads, reads and
// clears; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
    import lsqga_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_WAIT  = 800;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [1:0]               req_type;
    logic [IDX_W-1:0]         feature_index;
    logic signed [DATA_W-1:0] x_value;
    logic signed [DATA_W-1:0] prox_coef_value;
    logic signed [DATA_W-1:0] trial_coef_value;
    logic signed [DATA_W-1:0] mean_value;
    logic signed [DATA_W-1:0] y_value;
    logic                     last_element;
    logic                     resp_valid;
    logic                     resp_kind;
    logic signed [ACC_W-1:0]  gradient_value;
    logic [ACC_W-2:0]         fn_sum;
    logic [ACC_W-2:0]         qfn_sum;
    logic                     overflow;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [4:0]               paddr;
    logic [31:0]              pwdata;
    logic [31:0]              prdata;
    logic                     pready;

    int mismatches;
    int outstanding;
    int rows_seen;
    int reads_seen;
    int idle_pct;
    int beats_sent;
    int settings_used;
    int quiet_cycles;

    lsq_gradient_accumulator u_top (.*);

    lsqga_checker u_checker (.*);

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Watchdog: count cycles in which no beat moves on either channel.
    always @(posedge clk)
    begin
        if ((start && !busy) || resp_valid || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Q8.24 value: mostly moderate magnitudes, one in four over the full range.
    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return 32'($urandom_range(0, 1 << 26)) - 32'(1 << 25);
    endfunction

    // Issue one command beat; hold it until the block takes it.
    task automatic issue(req_t kind, int idx, logic [31:0] x, logic [31:0] pc,
                         logic [31:0] tc, logic [31:0] mean, logic [31:0] y,
                         logic last);
        bit taken;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start            <= 1'b1;
        req_type         <= kind;
        feature_index    <= idx[IDX_W-1:0];
        x_value          <= x;
        prox_coef_value  <= pc;
        trial_coef_value <= tc;
        mean_value       <= mean;
        y_value          <= y;
        last_element     <= last;
        do
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        while (!taken);
        beats_sent++;
    endtask

    // Noise on fields that the command kind ignores.
    task automatic issue_elem(int idx, logic [31:0] x, logic [31:0] y, logic last);
        issue(REQ_ELEM, idx, x, $urandom, $urandom, $urandom, y, last);
    endtask

    task automatic issue_load(int idx, logic [31:0] pc, logic [31:0] tc, logic [31:0] mean);
        issue(REQ_LOAD, idx, $urandom, pc, tc, mean, $urandom, 1'($urandom_range(0, 1)));
    endtask

    task automatic issue_plain(req_t kind, int idx);
        issue(kind, idx, $urandom, $urandom, $urandom, $urandom, $urandom,
              1'($urandom_range(0, 1)));
    endtask

    // Hold off until every expected result is back and the queue is no longer full.
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0 || busy)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic reg_write(reg_idx_t which, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic program_regs(logic [1:0] mode, logic act, logic [6:0] len,
                                logic [31:0] pi, logic [31:0] ti);
        settle();
        reg_write(REG_MODE, 32'(mode));
        reg_write(REG_ACTIVE_SET, 32'(act));
        reg_write(REG_LENGTH, 32'(len));
        reg_write(REG_PROX_ICPT, pi);
        reg_write(REG_TRIAL_ICPT, ti);
        settings_used++;
    endtask

    initial
    begin
        int          lens[10] = '{4, 1, 0, 64, 127, 2, 8, 3, 16, 5};
        int          phase_idle[4] = '{0, 67, 6, 0};
        int          n;
        int          pos;
        int          pick;
        int          idx;
        logic        last;
        logic [31:0] pi;
        logic [31:0] ti;

        rst_n            = 1'b0;
        start            = 1'b0;
        req_type         = REQ_LOAD;
        feature_index    = '0;
        x_value          = '0;
        prox_coef_value  = '0;
        trial_coef_value = '0;
        mean_value       = '0;
        y_value          = '0;
        last_element     = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        idle_pct         = 0;
        beats_sent       = 0;
        settings_used    = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the whole row buffer once so no row end reads an unwritten entry.
        for (int i = 0; i < MAX_FEATURES; i++)
            issue_elem(i, pick_value(), pick_value(), i == MAX_FEATURES - 1);

        // Directed: extreme loads and elements, element beyond the active
        // length, reads, mode three, empty length, clear.
        program_regs(MODE_GRAD, 1'b0, 7'd4, 32'h7fff_ffff, 32'h8000_0000);
        issue_load(0, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
        issue_load(1, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        issue_load(2, 32'd0, 32'd0, 32'd0);
        issue_load(3, 32'h0100_0000, 32'hff00_0000, 32'h0080_0000);
        issue_load(63, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
        issue_elem(0, 32'h7fff_ffff, 32'd0, 1'b0);
        issue_elem(1, 32'h8000_0000, 32'd0, 1'b0);
        issue_elem(5, 32'h1234_5678, 32'd0, 1'b0);
        issue_elem(3, 32'h8000_0000, 32'h7fff_ffff, 1'b1);
        issue_plain(REQ_READ, 0);
        issue_plain(REQ_READ, 1);
        issue_plain(REQ_READ, 63);
        program_regs(MODE_BOTH, 1'b1, 7'd2, 32'h8000_0000, 32'h7fff_ffff);
        issue_elem(0, 32'h8000_0000, 32'h8000_0000, 1'b0);
        issue_elem(1, 32'h7fff_ffff, 32'h8000_0000, 1'b1);
        program_regs(2'd3, 1'b0, 7'd0, 32'd0, 32'd0);
        issue_elem(0, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
        issue_plain(REQ_CLEAR, 0);
        issue_plain(REQ_READ, 0);

        // Random segments: each gets its own register setting and idle phase.
        for (int seg = 0; seg < 10; seg++)
        begin
            pi = (seg % 3 == 0) ? pick_value() : 32'h8000_0000 ^ (seg[0] ? 32'hffff_ffff : 0);
            ti = (seg % 3 == 1) ? 32'h7fff_ffff : pick_value();
            program_regs(2'(seg % 4), seg[1], 7'(lens[seg]), pi, ti);
            idle_pct = phase_idle[seg % 4];
            n   = (lens[seg] > MAX_FEATURES) ? MAX_FEATURES : lens[seg];
            pos = 0;
            for (int k = 0; k < 170; k++)
            begin
                pick = $urandom_range(0, 99);
                // midway through the segment, wait until every result is back
                if (k == 85)
                    settle();
                if (pick < 60)
                begin
                    if (n == 0)
                        issue_elem($urandom_range(0, 63), pick_value(), pick_value(), 1'b1);
                    else
                    begin
                        last = (pos == n - 1) || ($urandom_range(0, 19) == 0);
                        issue_elem(pos, pick_value(), pick_value(), last);
                        pos = last ? 0 : pos + 1;
                    end
                end
                else if (pick < 75)
                    issue_load($urandom_range(0, 63),
                               ($urandom_range(0, 3) == 0) ? 32'd0 : pick_value(),
                               pick_value(), pick_value());
                else if (pick < 90)
                    issue_plain(REQ_READ, $urandom_range(0, 63));
                else if (pick < 93)
                    issue_plain(REQ_CLEAR, $urandom_range(0, 63));
                else
                begin
                    // stray element: random position, possibly ending the row early
                    idx  = $urandom_range(0, 63);
                    last = 1'($urandom_range(0, 1));
                    issue_elem(idx, pick_value(), pick_value(), last);
                    if (last)
                        pos = 0;
                end
            end
        end

        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Covered %0d command beats over %0d register settings (modes 0-3,",
                 beats_sent, settings_used);
        $display("lengths 0 to 127): %0d row ends and %0d gradient reads checked.",
                 rows_seen, reads_seen);
        if (mismatches == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
